// ----- design/uwt_pkg.sv -----
package uwt_pkg;

    localparam int DEF_ENTRIES = 128;

    localparam int OP_W   = 3;
    localparam int ID_W   = 32;
    localparam int SLOT_W = 7;
    localparam int ST_W   = 2;
    localparam int POS_W  = 7;
    localparam int VC_W   = 8;

    localparam logic [OP_W-1:0] OP_SEARCH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP       = 2'd2;

    typedef struct packed {
        logic load;
        logic scan;
        logic fetch;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_end;
        logic            hit;
        logic            free;
        logic            out_free;
    } sts_t;

endpackage

// ----- design/uwt_ram.sv -----
module uwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/uwt_ctrl.sv -----
module uwt_ctrl
    import uwt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_SCAN     = 6'b000100,
        S_RESOLVE  = 6'b001000,
        S_FETCH    = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_SEARCH, OP_ADD, OP_DELETE: state_next = S_SCAN;
                    OP_READ:                      state_next = S_FETCH;
                    default:                      state_next = S_FINISH;
                endcase
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                // add with no match and no free slot needs the victim's id
                if (sts.op == OP_ADD && !sts.hit && !sts.free)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/uwt_dp.sv -----
module uwt_dp
    import uwt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [OP_W-1:0]   op,
    input  logic [ID_W-1:0]   card_id,
    input  logic [SLOT_W-1:0] slot,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ST_W-1:0]   status,
    output logic [POS_W-1:0]  position,
    output logic              evicted,
    output logic [ID_W-1:0]   evicted_id,
    output logic [ID_W-1:0]   read_id,
    output logic [VC_W-1:0]   valid_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    logic [OP_W-1:0]    op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   addr_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               out_valid_reg;
    logic [ST_W-1:0]    status_reg, status_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ev_reg, ev_next;
    logic [ID_W-1:0]    evid_reg, evid_next;
    logic [ID_W-1:0]    rdid_reg, rdid_next;
    logic [VC_W-1:0]    vcnt_reg;

    logic [ID_W-1:0]  ram_q;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;
    logic             match_now;
    logic             free_now;

    assign slot_idx  = IDX_W'(slot_reg);
    assign slot_ok   = (CMP_W'(slot_reg) < CMP_W'(ENTRIES)) && valid_reg[slot_idx];
    assign match_now = cmp_vld_reg && valid_reg[cmp_idx_reg] && (ram_q == id_reg);
    assign free_now  = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    assign ram_re    = cmd.scan || cmd.fetch;
    assign ram_raddr = cmd.scan ? addr_reg : ((op_reg == OP_READ) ? slot_idx : ptr_reg);
    assign ram_waddr = free_reg ? free_idx_reg : ptr_reg;
    assign ram_we    = cmd.finish && (op_reg == OP_ADD) && !hit_reg;

    uwt_ram #(
        .WIDTH(ID_W),
        .DEPTH(ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (id_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        sts.op       = op_reg;
        sts.scan_end = cmp_vld_reg && (match_now || cmp_idx_reg == LAST);
        sts.hit      = hit_reg;
        sts.free     = free_reg;
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        valid_next  = valid_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        status_next = ST_NOT_FOUND;
        pos_next    = '0;
        ev_next     = 1'b0;
        evid_next   = '0;
        rdid_next   = '0;
        unique case (op_reg)
            OP_SEARCH:
            begin
                if (hit_reg)
                begin
                    status_next = ST_OK;
                    pos_next    = POS_W'(hit_idx_reg);
                end
            end
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    status_next = ST_DUP;
                    pos_next    = POS_W'(hit_idx_reg);
                end
                else if (free_reg)
                begin
                    status_next              = ST_OK;
                    pos_next                 = POS_W'(free_idx_reg);
                    valid_next[free_idx_reg] = 1'b1;
                    count_next               = count_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_OK;
                    pos_next    = POS_W'(ptr_reg);
                    ev_next     = 1'b1;
                    evid_next   = ram_q;
                    ptr_next    = (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (hit_reg)
                begin
                    status_next             = ST_OK;
                    pos_next                = POS_W'(hit_idx_reg);
                    valid_next[hit_idx_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                pos_next = POS_W'(slot_reg);
                if (slot_ok)
                begin
                    status_next = ST_OK;
                    rdid_next   = ram_q;
                end
            end
            OP_CLEAR:
            begin
                valid_next  = '0;
                count_next  = '0;
                ptr_next    = '0;
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            addr_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                addr_reg    <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
            end
            else if (cmd.scan)
            begin
                addr_reg    <= (addr_reg == LAST) ? '0 : addr_reg + 1'b1;
                cmp_vld_reg <= 1'b1;
                if (match_now && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_now && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                ptr_reg   <= ptr_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            id_reg   <= card_id;
            slot_reg <= slot;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= addr_reg;
            if (match_now && !hit_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (free_now && !free_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            ev_reg     <= ev_next;
            evid_reg   <= evid_next;
            rdid_reg   <= rdid_next;
            vcnt_reg   <= VC_W'(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = pos_reg;
    assign evicted     = ev_reg;
    assign evicted_id  = evid_reg;
    assign read_id     = rdid_reg;
    assign valid_count = vcnt_reg;

endmodule

// ----- design/uid_whitelist_table.sv -----
// Card identifier whitelist: ENTRIES 32-bit ids, each slot with a valid bit.
// Request channel (in_valid/in_ready) carries op, card_id and slot; the result
// channel (out_valid/out_ready) carries status, position, evicted, evicted_id,
// read_id and valid_count, exactly one result per request.
// Ops: search, add (lowest free slot, else round-robin replace), delete,
// read slot, clear all.
// One request is worked on at a time. Search, add and delete walk the id RAM
// one slot per cycle through its single read port, stopping at the first
// match or after the last slot; an add that replaces then reads the victim's
// id. Read slot reads its slot once; clear and unknown ops read no slot.
// The next request can be taken in the cycle after the result is loaded.
// The result sits in an output register; in_ready rises again as soon as it
// is loaded, so the next request is taken while the result waits. If the
// receiver stalls, a finished request waits until the output register frees.
// Reset clears valid bits, the count and the replace pointer at once; the id
// RAM is not cleared and needs no clearing pass.
module uid_whitelist_table
    import uwt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   op,
    input  logic [ID_W-1:0]   card_id,
    input  logic [SLOT_W-1:0] slot,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ST_W-1:0]   status,
    output logic [POS_W-1:0]  position,
    output logic              evicted,
    output logic [ID_W-1:0]   evicted_id,
    output logic [ID_W-1:0]   read_id,
    output logic [VC_W-1:0]   valid_count
);

    cmd_t cmd;
    sts_t sts;

    uwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    uwt_dp #(
        .ENTRIES(ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .card_id     (card_id),
        .slot        (slot),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .evicted     (evicted),
        .evicted_id  (evicted_id),
        .read_id     (read_id),
        .valid_count (valid_count)
    );

endmodule

// ----- sim/uid_whitelist_table_tb.sv -----
module uid_whitelist_table_tb;
    import uwt_pkg::*;

    localparam int ENTRIES        = DEF_ENTRIES;
    localparam int POOL_SIZE      = 48;
    localparam int TOTAL_REQUESTS = 970;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 200;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] position;
        logic             evicted;
        logic [ID_W-1:0]  evicted_id;
        logic [ID_W-1:0]  read_id;
        logic [VC_W-1:0]  valid_count;
    } lookup_result_t;

    class whitelist_scoreboard;
        bit              valid_map[ENTRIES];
        logic [ID_W-1:0] id_store[ENTRIES];
        int              entry_count;
        int              replace_ptr;
        lookup_result_t  expected_results[$];
        int              errors;

        function new();
            foreach (valid_map[i])
            begin
                valid_map[i] = 1'b0;
                id_store[i]  = '0;
            end
            entry_count = 0;
            replace_ptr = 0;
            errors      = 0;
        endfunction

        function int lowest_match(logic [ID_W-1:0] id);
            int i;
            for (i = 0; i < ENTRIES; i++)
            begin
                if (valid_map[i] && id_store[i] == id)
                    return i;
            end
            return -1;
        endfunction

        function int pick_valid_slot();
            int s;
            s = $urandom_range(0, ENTRIES - 1);
            if (entry_count == 0)
                return s;
            while (!valid_map[s])
                s = $urandom_range(0, ENTRIES - 1);
            return s;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(logic [OP_W-1:0] req_op, logic [ID_W-1:0] req_id,
                                   logic [SLOT_W-1:0] req_slot);
            lookup_result_t r;
            int hit;
            int pos;
            int i;
            r        = '0;
            r.status = ST_NOT_FOUND;
            case (req_op)
                OP_SEARCH:
                begin
                    hit = lowest_match(req_id);
                    if (hit >= 0)
                    begin
                        r.status   = ST_OK;
                        r.position = POS_W'(hit);
                    end
                end
                OP_ADD:
                begin
                    hit = lowest_match(req_id);
                    if (hit >= 0)
                    begin
                        r.status   = ST_DUP;
                        r.position = POS_W'(hit);
                    end
                    else
                    begin
                        pos = -1;
                        for (i = ENTRIES - 1; i >= 0; i--)
                        begin
                            if (!valid_map[i])
                                pos = i;
                        end
                        if (pos >= 0)
                        begin
                            valid_map[pos] = 1'b1;
                            entry_count++;
                        end
                        else
                        begin
                            // full: round-robin replacement
                            pos          = replace_ptr;
                            r.evicted    = 1'b1;
                            r.evicted_id = id_store[pos];
                            replace_ptr  = (pos + 1) % ENTRIES;
                        end
                        id_store[pos] = req_id;
                        r.status      = ST_OK;
                        r.position    = POS_W'(pos);
                    end
                end
                OP_DELETE:
                begin
                    hit = lowest_match(req_id);
                    if (hit >= 0)
                    begin
                        valid_map[hit] = 1'b0;
                        if (entry_count > 0)
                            entry_count--;
                        r.status   = ST_OK;
                        r.position = POS_W'(hit);
                    end
                end
                OP_READ:
                begin
                    r.position = req_slot;
                    if (int'(req_slot) < ENTRIES && valid_map[req_slot])
                    begin
                        r.status  = ST_OK;
                        r.read_id = id_store[req_slot];
                    end
                end
                OP_CLEAR:
                begin
                    foreach (valid_map[j])
                        valid_map[j] = 1'b0;
                    entry_count = 0;
                    replace_ptr = 0;
                    r.status    = ST_OK;
                end
                default:
                begin
                end
            endcase
            r.valid_count = VC_W'(entry_count);
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            check_field("status", ID_W'(want.status), ID_W'(got.status));
            check_field("position", ID_W'(want.position), ID_W'(got.position));
            check_field("evicted", ID_W'(want.evicted), ID_W'(got.evicted));
            check_field("evicted_id", want.evicted_id, got.evicted_id);
            check_field("read_id", want.read_id, got.read_id);
            check_field("valid_count", ID_W'(want.valid_count), ID_W'(got.valid_count));
        endfunction
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op        = OP_SEARCH;
    logic [ID_W-1:0]   card_id   = '0;
    logic [SLOT_W-1:0] slot      = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ST_W-1:0]   status;
    logic [POS_W-1:0]  position;
    logic              evicted;
    logic [ID_W-1:0]   evicted_id;
    logic [ID_W-1:0]   read_id;
    logic [VC_W-1:0]   valid_count;

    whitelist_scoreboard sb = new();
    logic [ID_W-1:0]     id_pool[POOL_SIZE];
    int                  requests_sent = 0;
    bit                  hold_results  = 1'b0;
    bit                  tx_calm       = 1'b0;

    uid_whitelist_table #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .card_id(card_id),
        .slot(slot),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .position(position),
        .evicted(evicted),
        .evicted_id(evicted_id),
        .read_id(read_id),
        .valid_count(valid_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("uid_whitelist_table test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(input logic [OP_W-1:0] req_op, input logic [ID_W-1:0] req_id,
                                input logic [SLOT_W-1:0] req_slot);
        int gap;
        in_valid <= 1'b1;
        op       <= req_op;
        card_id  <= req_id;
        slot     <= req_slot;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(req_op, req_id, req_slot);
        requests_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_mixed();
        int r;
        int w;
        logic [ID_W-1:0] id;
        r = $urandom_range(0, 99);
        w = $urandom_range(0, 3);
        if (w == 0)
            id = $urandom;
        else if (w == 1)
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            id = sb.id_store[sb.pick_valid_slot()];
        if (r < 35)
            send_request(OP_ADD, id, SLOT_W'($urandom));
        else if (r < 60)
            send_request(OP_SEARCH, id, SLOT_W'($urandom));
        else if (r < 75)
            send_request(OP_DELETE, id, SLOT_W'($urandom));
        else if (r < 93)
            send_request(OP_READ, $urandom,
                         SLOT_W'(w < 2 ? $urandom : sb.pick_valid_slot()));
        else if (r < 97)
            send_request(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                         $urandom, SLOT_W'($urandom));
        else if (r < 98)
            send_request(OP_CLEAR, $urandom, SLOT_W'($urandom));
        else
            send_request(OP_ADD, $urandom, SLOT_W'($urandom));
    endtask

    task automatic send_noise();
        send_request(OP_W'($urandom), $urandom, SLOT_W'($urandom));
    endtask

    // fill to capacity, then keep adding so the replace pointer walks
    task automatic fill_table(input int evictions);
        int r;
        int s;
        while (sb.entry_count < ENTRIES)
        begin
            r = $urandom_range(0, 99);
            s = sb.pick_valid_slot();
            if (r < 85)
                send_request(OP_ADD, $urandom, SLOT_W'($urandom));
            else if (r < 93)
                send_request(OP_ADD, sb.id_store[s], SLOT_W'($urandom));
            else
                send_request(OP_SEARCH, sb.id_store[s], SLOT_W'($urandom));
        end
        repeat (evictions)
        begin
            r = $urandom_range(0, 99);
            s = sb.pick_valid_slot();
            if (r < 70)
                send_request(OP_ADD, $urandom, SLOT_W'($urandom));
            else if (r < 85)
                send_request(OP_SEARCH, sb.id_store[s], SLOT_W'($urandom));
            else
                send_request(OP_READ, $urandom, SLOT_W'(s));
        end
    endtask

    initial
    begin : result_sink
        int  stall_left;
        int  r;
        bit  calm;
        stall_left = 0;
        calm       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result({status, position, evicted, evicted_id, read_id, valid_count});
            if (hold_results)
            begin
                hold_results = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    calm = !calm;
                r = $urandom_range(0, 99);
                if (!calm && r < 15)
                begin
                    stall_left = (r < 2) ? $urandom_range(20, 100) : $urandom_range(0, 3);
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_SEARCH, 32'h0000_0000, '0);
        send_request(OP_READ, $urandom, '0);
        send_request(OP_READ, $urandom, '1);
        send_request(OP_DELETE, 32'hFFFF_FFFF, '0);
        send_request(OP_ADD, 32'h0000_0000, '0);
        send_request(OP_ADD, 32'hFFFF_FFFF, '1);
        send_request(OP_ADD, 32'h0000_0000, SLOT_W'($urandom));
        send_request(OP_SEARCH, 32'hFFFF_FFFF, SLOT_W'($urandom));
        send_request(OP_READ, $urandom, SLOT_W'(1));
        send_request(OP_ADD, 32'h1234_5678, SLOT_W'($urandom));
        send_request(OP_DELETE, 32'h0000_0000, SLOT_W'($urandom));
        send_request(OP_SEARCH, 32'h0000_0000, SLOT_W'($urandom));
        send_request(OP_ADD, 32'hA5A5_A5A5, SLOT_W'($urandom));
        send_request(OP_READ, $urandom, '0);
        for (i = OP_UNUSED_FIRST; i <= OP_UNUSED_LAST; i++)
            send_request(OP_W'(i), $urandom, SLOT_W'($urandom));
        send_request(OP_CLEAR, $urandom, SLOT_W'($urandom));
        send_request(OP_SEARCH, 32'hFFFF_FFFF, SLOT_W'($urandom));
        send_request(OP_READ, $urandom, SLOT_W'(1));
        send_request(OP_ADD, 32'h5A5A_5A5A, SLOT_W'($urandom));

        repeat (120) send_mixed();
        hold_results = 1'b1;
        fill_table(140);
        repeat (150) send_mixed();
        drain_results();
        repeat (40) send_noise();
        send_request(OP_CLEAR, $urandom, SLOT_W'($urandom));
        fill_table(20);
        while (requests_sent < TOTAL_REQUESTS)
            send_mixed();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("uid_whitelist_table test passed");
        else
            $display("uid_whitelist_table test failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/uwt_pkg.sv
design/uwt_ram.sv
design/uwt_ctrl.sv
design/uwt_dp.sv
design/uid_whitelist_table.sv
sim/uid_whitelist_table_tb.sv
